@@ rtl/hduart_pkg.sv @@
// Package: word types, event kinds and status codes for the half-duplex UART buffer controller.
package hduart_pkg;

  localparam logic [2:0] KIND_HOST_WRITE = 3'd0;
  localparam logic [2:0] KIND_HOST_READ  = 3'd1;
  localparam logic [2:0] KIND_LINE_RX    = 3'd2;
  localparam logic [2:0] KIND_TX_SLOT    = 3'd3;
  localparam logic [2:0] KIND_TICK       = 3'd4;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TX_FULL     = 3'd1;
  localparam logic [2:0] ST_RX_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_PENDING     = 3'd3;
  localparam logic [2:0] ST_TIMEOUT     = 3'd4;
  localparam logic [2:0] ST_RX_OFF      = 3'd5;

  localparam logic [7:0] TIMEOUT_RESET = 8'd100;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic       read_valid;
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       transmit_mode;
  } out_t;

  typedef struct packed {
    logic step;
  } cmd_t;

  typedef enum logic [1:0] {
    S_EMPTY = 2'b01,
    S_FULL  = 2'b10
  } state_e;

endpackage

@@ rtl/half_duplex_uart_buffer_ctrl.sv @@
// Top level: half-duplex UART buffer controller, handshake controller plus ring datapath.
// The result word is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle while the result side keeps taking words.
// Both come from the single result register, refilled as its word leaves.
// Reset: rst_ni low clears ring pointers, direction (receive), read wait, the
// result register and loads the timeout register with 100; ring contents are not cleared.
module half_duplex_uart_buffer_ctrl #(
  parameter int RX_DEPTH = 32,
  parameter int TX_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hduart_pkg::in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hduart_pkg::out_t  out_data_o,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i
);

  hduart_pkg::cmd_t cmd;

  hduart_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  hduart_dp #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/hduart_ctrl.sv @@
// Controller: handshake state machine that issues one step per accepted word.
module hduart_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hduart_pkg::cmd_t  cmd_o
);

  hduart_pkg::state_e state_q, state_d;
  logic step;

  always_comb begin
    in_ready_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      hduart_pkg::S_EMPTY: begin
        in_ready_o  = 1'b1;
        out_valid_o = 1'b0;
      end
      hduart_pkg::S_FULL: begin
        in_ready_o  = out_ready_i;
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
  end

  assign step = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      hduart_pkg::S_EMPTY: begin
        if (step) state_d = hduart_pkg::S_FULL;
      end
      hduart_pkg::S_FULL: begin
        if (out_ready_i && !step) state_d = hduart_pkg::S_EMPTY;
      end
      default: state_d = hduart_pkg::S_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hduart_pkg::S_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.step = step;

endmodule

@@ rtl/hduart_dp.sv @@
// Datapath: receive and transmit rings, line direction, read wait timer and result register.
module hduart_dp #(
  parameter int RX_DEPTH = 32,
  parameter int TX_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hduart_pkg::cmd_t  cmd_i,
  input  hduart_pkg::in_t   in_data_i,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  output hduart_pkg::out_t  out_data_o
);

  localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];

  logic [RX_AW-1:0] rx_wp_q, rx_wp_d, rx_rp_q, rx_rp_d, rx_wp_nx, rx_rp_nx;
  logic [TX_AW-1:0] tx_wp_q, tx_wp_d, tx_rp_q, tx_rp_d, tx_wp_nx, tx_rp_nx;
  logic             dir_q, dir_d, waiting_q, waiting_d, armed_q, armed_d;
  logic [7:0]       count_q, count_d, timeout_q;
  logic             rx_we, tx_we;

  logic [2:0] status_q, status_d;
  logic       rvalid_q, rvalid_d, rsel_q, rsel_d, tvalid_q, tvalid_d;
  logic [7:0] rbyte_q, rx_rd_q, tx_rd_q;

  assign rx_wp_nx = (rx_wp_q == RX_LAST) ? '0 : rx_wp_q + 1'b1;
  assign rx_rp_nx = (rx_rp_q == RX_LAST) ? '0 : rx_rp_q + 1'b1;
  assign tx_wp_nx = (tx_wp_q == TX_LAST) ? '0 : tx_wp_q + 1'b1;
  assign tx_rp_nx = (tx_rp_q == TX_LAST) ? '0 : tx_rp_q + 1'b1;

  always_comb begin
    rx_wp_d   = rx_wp_q;
    rx_rp_d   = rx_rp_q;
    tx_wp_d   = tx_wp_q;
    tx_rp_d   = tx_rp_q;
    dir_d     = dir_q;
    waiting_d = waiting_q;
    armed_d   = armed_q;
    count_d   = count_q;
    rx_we     = 1'b0;
    tx_we     = 1'b0;
    status_d  = hduart_pkg::ST_OK;
    rvalid_d  = 1'b0;
    rsel_d    = 1'b0;
    tvalid_d  = 1'b0;
    case (in_data_i.kind)
      hduart_pkg::KIND_HOST_WRITE: begin
        if (tx_wp_nx == tx_rp_q) begin
          status_d = hduart_pkg::ST_TX_FULL;
        end else begin
          tx_we   = 1'b1;
          tx_wp_d = tx_wp_nx;
          dir_d   = 1'b1;
        end
      end
      hduart_pkg::KIND_HOST_READ: begin
        if (rx_rp_q != rx_wp_q) begin
          rvalid_d  = 1'b1;
          rx_rp_d   = rx_rp_nx;
          waiting_d = 1'b0;
          armed_d   = 1'b0;
        end else begin
          status_d  = hduart_pkg::ST_PENDING;
          waiting_d = 1'b1;
          armed_d   = !dir_q;
          if (!dir_q) count_d = timeout_q;
        end
      end
      hduart_pkg::KIND_LINE_RX: begin
        if (dir_q) begin
          status_d = hduart_pkg::ST_RX_OFF;
        end else if (waiting_q) begin
          rvalid_d  = 1'b1;
          rsel_d    = 1'b1;
          waiting_d = 1'b0;
          armed_d   = 1'b0;
        end else if (rx_wp_nx == rx_rp_q) begin
          status_d = hduart_pkg::ST_RX_OVERFLOW;
        end else begin
          rx_we   = 1'b1;
          rx_wp_d = rx_wp_nx;
        end
      end
      hduart_pkg::KIND_TX_SLOT: begin
        if (tx_rp_q == tx_wp_q) begin
          dir_d = 1'b0;
          if (waiting_q && !armed_q) begin
            armed_d = 1'b1;
            count_d = timeout_q;
          end
        end else begin
          tvalid_d = 1'b1;
          tx_rp_d  = tx_rp_nx;
        end
      end
      hduart_pkg::KIND_TICK: begin
        if (waiting_q) begin
          status_d = hduart_pkg::ST_PENDING;
          if (armed_q) begin
            if (count_q <= 8'd1) begin
              count_d   = '0;
              armed_d   = 1'b0;
              waiting_d = 1'b0;
              status_d  = hduart_pkg::ST_TIMEOUT;
            end else begin
              count_d = count_q - 8'd1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wp_q   <= '0;
      rx_rp_q   <= '0;
      tx_wp_q   <= '0;
      tx_rp_q   <= '0;
      dir_q     <= 1'b0;
      waiting_q <= 1'b0;
      armed_q   <= 1'b0;
      count_q   <= '0;
      status_q  <= hduart_pkg::ST_OK;
      rvalid_q  <= 1'b0;
      rsel_q    <= 1'b0;
      tvalid_q  <= 1'b0;
    end else if (cmd_i.step) begin
      rx_wp_q   <= rx_wp_d;
      rx_rp_q   <= rx_rp_d;
      tx_wp_q   <= tx_wp_d;
      tx_rp_q   <= tx_rp_d;
      dir_q     <= dir_d;
      waiting_q <= waiting_d;
      armed_q   <= armed_d;
      count_q   <= count_d;
      status_q  <= status_d;
      rvalid_q  <= rvalid_d;
      rsel_q    <= rsel_d;
      tvalid_q  <= tvalid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= hduart_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      rbyte_q <= in_data_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      if (rx_we) rx_mem[rx_wp_q] <= in_data_i.data;
      rx_rd_q <= rx_mem[rx_rp_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      if (tx_we) tx_mem[tx_wp_q] <= in_data_i.data;
      tx_rd_q <= tx_mem[tx_rp_q];
    end
  end

  assign out_data_o.status        = status_q;
  assign out_data_o.read_valid    = rvalid_q;
  assign out_data_o.read_data     = !rvalid_q ? 8'd0 : (rsel_q ? rbyte_q : rx_rd_q);
  assign out_data_o.tx_valid      = tvalid_q;
  assign out_data_o.tx_byte       = tvalid_q ? tx_rd_q : 8'd0;
  assign out_data_o.transmit_mode = dir_q;

endmodule

@@ rtl/hduart_chk.sv @@
// Checker: port-level assertions for the buffer controller, bound to the top level.
module hduart_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input hduart_pkg::out_t  out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed or dropped while stalled");

  a_word_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted word produced no result");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_tx_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.tx_valid |-> out_data_o.transmit_mode)
    else $error("byte sent while line in receive mode");

  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.read_valid |-> out_data_o.status == hduart_pkg::ST_OK)
    else $error("read byte delivered with error status");

endmodule

bind half_duplex_uart_buffer_ctrl hduart_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
